/* src/cdq_pkg.sv */
// Package for the cubic disorientation angle pipeline.
// Holds widths, fixed-point constants, the arctangent table, bus types and helpers.
// No dependencies; every other file of the block uses it.
package cdq_pkg;

    localparam int IN_W         = 16;
    localparam int OUT_W        = 15;
    localparam int PROD_W       = 32;
    localparam int D_W          = 34;
    localparam int P_W          = 35;
    localparam int Q_W          = 36;
    localparam int M_W          = 30;
    localparam int CAND_W       = 45;
    localparam int C_W          = 31;
    localparam int SQ_W         = 62;
    localparam int SQ_STEPS     = 31;
    localparam int X_W          = 33;
    localparam int Z_W          = 23;
    localparam int CORDIC_STEPS = 20;

    localparam int N_COMP = 4;
    localparam int N_PAIR = 12;
    localparam int N_QUAD = 8;
    localparam int N_CAND = N_COMP + N_PAIR + N_QUAD;
    localparam int N_PAIRIDX = N_PAIR / 2;

    // 0.707 in Q0.16
    localparam logic [15:0] K_PAIR = 16'd46334;

    localparam logic [CAND_W-1:0] ONE_Q44  = {1'b1, 44'd0};
    localparam logic [SQ_W-1:0]   ONE_Q60  = {2'b01, 60'd0};
    // Saturation points: at these magnitudes a candidate already reaches one
    localparam logic [M_W-1:0]    LIM_COMP = {2'b01, 28'd0};
    localparam logic [M_W-1:0]    LIM_WIDE = {1'b1, 29'd0};
    localparam logic [OUT_W-1:0]  OUT_MAX  = 15'd25736;
    localparam logic signed [Z_W-1:0] Z_ROUND = 23'sd32;

    // Pair index lists: (0,1) (2,3) (0,2) (1,3) (0,3) (1,2)
    localparam int PAIR_A [N_PAIRIDX] = '{0, 2, 0, 1, 0, 1};
    localparam int PAIR_B [N_PAIRIDX] = '{1, 3, 2, 3, 3, 2};

    // Arctangent of 2^-i in Q20
    localparam logic signed [Z_W-1:0] ATAN_Q20 [CORDIC_STEPS] = '{
        23'sd823550, 23'sd486170, 23'sd256879, 23'sd130396, 23'sd65451,
        23'sd32757,  23'sd16383,  23'sd8192,   23'sd4096,   23'sd2048,
        23'sd1024,   23'sd512,    23'sd256,    23'sd128,    23'sd64,
        23'sd32,     23'sd16,     23'sd8,      23'sd4,      23'sd2
    };

    typedef logic signed [IN_W-1:0] t_in_word;

    typedef struct packed {
        t_in_word w;
        t_in_word x;
        t_in_word y;
        t_in_word z;
    } t_quat;

    typedef struct packed {
        logic                          valid;
        logic [N_CAND-1:0][M_W-1:0]    mag;
    } t_mag_bus;

    typedef struct packed {
        logic           valid;
        logic [C_W-1:0] c;
    } t_cos_bus;

    typedef struct packed {
        logic           valid;
        logic [C_W-1:0] c;
        logic [C_W-1:0] s;
    } t_root_bus;

    typedef struct packed {
        logic             valid;
        logic [OUT_W-1:0] angle;
    } t_ang_bus;

    // Absolute value, saturated at lim
    function automatic logic [M_W-1:0] f_sat_mag(input logic signed [Q_W-1:0] v,
                                                 input logic [M_W-1:0] lim);
        logic [Q_W-1:0] a;
        a = v[Q_W-1] ? Q_W'(-v) : Q_W'(v);
        if (a >= {{(Q_W-M_W){1'b0}}, lim}) begin
            return lim;
        end
        return a[M_W-1:0];
    endfunction

    function automatic logic [CAND_W-1:0] f_max(input logic [CAND_W-1:0] a,
                                                 input logic [CAND_W-1:0] b);
        return (a > b) ? a : b;
    endfunction

endpackage

/* src/cdq_if.sv */
// Stream interfaces of the cubic disorientation block: input pair and result.
// Each carries valid, ready and payload; widths come from cdq_pkg.
interface cdq_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [cdq_pkg::IN_W-1:0]     a_w;
    logic signed [cdq_pkg::IN_W-1:0]     a_x;
    logic signed [cdq_pkg::IN_W-1:0]     a_y;
    logic signed [cdq_pkg::IN_W-1:0]     a_z;
    logic signed [cdq_pkg::IN_W-1:0]     b_w;
    logic signed [cdq_pkg::IN_W-1:0]     b_x;
    logic signed [cdq_pkg::IN_W-1:0]     b_y;
    logic signed [cdq_pkg::IN_W-1:0]     b_z;

    modport source (output valid, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z, input ready);
    modport sink   (input valid, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z, output ready);
endinterface

interface cdq_out_if;
    logic                          valid;
    logic                          ready;
    logic [cdq_pkg::OUT_W-1:0]     disorientation_angle;

    modport source (output valid, disorientation_angle, input ready);
    modport sink   (input valid, disorientation_angle, output ready);
endinterface

/* src/cubic_disorientation_quaternion.sv */
// Cubic disorientation angle of two quaternions, 63-stage pipeline.
// Throughput one transaction per cycle while the output register is free or being emptied.
// Depth is set by the 31-stage square root and the 20-stage CORDIC chain.
// The whole pipeline holds while the output register is full and not taken.
// Synchronous active-low reset clears the valid bits only; no clearing pass.
module cubic_disorientation_quaternion (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cdq_in_if.sink    i_in,
    cdq_out_if.source o_out
);
    import cdq_pkg::*;

    logic      en;
    t_quat     w_a;
    t_quat     w_b;
    t_mag_bus  w_mag;
    t_cos_bus  w_cos;
    t_root_bus w_root;
    t_ang_bus  w_ang;

    // Advance whenever the output register is free or being emptied
    assign en         = !w_ang.valid || o_out.ready;
    assign i_in.ready = en;

    assign w_a.w = i_in.a_w;
    assign w_a.x = i_in.a_x;
    assign w_a.y = i_in.a_y;
    assign w_a.z = i_in.a_z;
    assign w_b.w = i_in.b_w;
    assign w_b.x = i_in.b_x;
    assign w_b.y = i_in.b_y;
    assign w_b.z = i_in.b_z;

    cdq_product u_product (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_in.valid),
        .i_a     (w_a),
        .i_b     (w_b),
        .o_mag   (w_mag)
    );

    cdq_max u_max (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_mag   (w_mag),
        .o_cos   (w_cos)
    );

    cdq_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_cos   (w_cos),
        .o_root  (w_root)
    );

    cdq_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_root  (w_root),
        .o_ang   (w_ang)
    );

    assign o_out.valid                = w_ang.valid;
    assign o_out.disorientation_angle = w_ang.angle;

endmodule

/* src/cdq_product.sv */
// Front end: quaternion products, relative rotation d = A * conj(B),
// pairwise sums and saturated magnitudes of all 24 candidates. Uses cdq_pkg.
module cdq_product (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  cdq_pkg::t_quat    i_a,
    input  cdq_pkg::t_quat    i_b,
    output cdq_pkg::t_mag_bus o_mag
);
    import cdq_pkg::*;

    t_in_word qa [4];
    t_in_word qb [4];

    logic signed [PROD_W-1:0] r_p [4][4];
    logic signed [PROD_W-1:0] n_p [4][4];
    logic signed [D_W-1:0]    r_d [4];
    logic signed [D_W-1:0]    n_d [4];
    logic signed [D_W-1:0]    r_dd [4];
    logic signed [P_W-1:0]    r_ps [N_PAIRIDX];
    logic signed [P_W-1:0]    r_pd [N_PAIRIDX];
    logic signed [P_W-1:0]    n_ps [N_PAIRIDX];
    logic signed [P_W-1:0]    n_pd [N_PAIRIDX];
    logic [N_CAND-1:0][M_W-1:0] r_mag;
    logic [N_CAND-1:0][M_W-1:0] n_mag;
    logic [3:0]               r_v;

    assign qa[0] = i_a.w;
    assign qa[1] = i_a.x;
    assign qa[2] = i_a.y;
    assign qa[3] = i_a.z;
    assign qb[0] = i_b.w;
    assign qb[1] = i_b.x;
    assign qb[2] = i_b.y;
    assign qb[3] = i_b.z;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
                n_p[i][j] = PROD_W'(qa[i]) * PROD_W'(qb[j]);
            end
        end
    end

    always_comb begin
        n_d[0] =  D_W'(r_p[0][0]) + D_W'(r_p[1][1]) + D_W'(r_p[2][2]) + D_W'(r_p[3][3]);
        n_d[1] = -D_W'(r_p[0][1]) + D_W'(r_p[1][0]) - D_W'(r_p[2][3]) + D_W'(r_p[3][2]);
        n_d[2] = -D_W'(r_p[0][2]) + D_W'(r_p[1][3]) + D_W'(r_p[2][0]) - D_W'(r_p[3][1]);
        n_d[3] = -D_W'(r_p[0][3]) - D_W'(r_p[1][2]) + D_W'(r_p[2][1]) + D_W'(r_p[3][0]);
    end

    always_comb begin
        for (int k = 0; k < N_PAIRIDX; k++) begin
            n_ps[k] = P_W'(r_d[PAIR_A[k]]) + P_W'(r_d[PAIR_B[k]]);
            n_pd[k] = P_W'(r_d[PAIR_A[k]]) - P_W'(r_d[PAIR_B[k]]);
        end
    end

    // Four-term sums reuse (d0 +- d1) and (d2 +- d3)
    always_comb begin
        logic signed [P_W-1:0] t01;
        logic signed [P_W-1:0] t23;
        logic [2:0]            sel;
        for (int k = 0; k < N_COMP; k++) begin
            n_mag[k] = f_sat_mag(Q_W'(r_dd[k]), LIM_COMP);
        end
        for (int k = 0; k < N_PAIRIDX; k++) begin
            n_mag[N_COMP + 2*k]     = f_sat_mag(Q_W'(r_ps[k]), LIM_WIDE);
            n_mag[N_COMP + 2*k + 1] = f_sat_mag(Q_W'(r_pd[k]), LIM_WIDE);
        end
        for (int i = 0; i < N_QUAD; i++) begin
            sel = 3'(i);
            t01 = sel[2] ? r_pd[0] : r_ps[0];
            unique case (sel[1:0])
                2'b00:   t23 =  r_ps[1];
                2'b01:   t23 =  r_pd[1];
                2'b10:   t23 = -r_pd[1];
                default: t23 = -r_ps[1];
            endcase
            n_mag[N_COMP + N_PAIR + i] = f_sat_mag(Q_W'(t01) + Q_W'(t23), LIM_WIDE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[2:0], i_valid};
        end
    end

    // Hold d one more stage so the components meet their own pair sums
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p   <= n_p;
            r_d   <= n_d;
            r_dd  <= r_d;
            r_ps  <= n_ps;
            r_pd  <= n_pd;
            r_mag <= n_mag;
        end
    end

    assign o_mag.valid = r_v[3];
    assign o_mag.mag   = r_mag;

endmodule

/* src/cdq_max.sv */
// Candidate scaling and registered maximum tree over the 24 candidates.
// Yields c, the clamped maximum in Q30. Uses cdq_pkg.
module cdq_max (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  cdq_pkg::t_mag_bus i_mag,
    output cdq_pkg::t_cos_bus o_cos
);
    import cdq_pkg::*;

    logic [CAND_W-1:0] r_cand [N_CAND];
    logic [CAND_W-1:0] n_cand [N_CAND];
    logic [CAND_W-1:0] r_l1 [12];
    logic [CAND_W-1:0] r_l2 [6];
    logic [CAND_W-1:0] r_l3 [3];
    logic [CAND_W-1:0] r_m;
    logic [4:0]        r_v;

    always_comb begin
        logic [M_W+15:0] prod;
        for (int k = 0; k < N_COMP; k++) begin
            n_cand[k] = {i_mag.mag[k][28:0], 16'd0};
        end
        for (int k = N_COMP; k < N_COMP + N_PAIR; k++) begin
            prod = i_mag.mag[k] * K_PAIR;
            n_cand[k] = (prod > (M_W+16)'(ONE_Q44)) ? ONE_Q44 : prod[CAND_W-1:0];
        end
        for (int k = N_COMP + N_PAIR; k < N_CAND; k++) begin
            n_cand[k] = {i_mag.mag[k], 15'd0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[3:0], i_mag.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cand <= n_cand;
            for (int k = 0; k < 12; k++) begin
                r_l1[k] <= f_max(r_cand[2*k], r_cand[2*k+1]);
            end
            for (int k = 0; k < 6; k++) begin
                r_l2[k] <= f_max(r_l1[2*k], r_l1[2*k+1]);
            end
            for (int k = 0; k < 3; k++) begin
                r_l3[k] <= f_max(r_l2[2*k], r_l2[2*k+1]);
            end
            r_m <= f_max(f_max(r_l3[0], r_l3[1]), r_l3[2]);
        end
    end

    assign o_cos.valid = r_v[4];
    assign o_cos.c     = r_m[CAND_W-1:14];

endmodule

/* src/cdq_sqrt.sv */
// Sine stage: s = floor(sqrt(1 - c*c)) in Q30 through a square, a subtract
// and a 31-stage bit-pair square root pipeline. Uses cdq_pkg.
module cdq_sqrt (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  cdq_pkg::t_cos_bus  i_cos,
    output cdq_pkg::t_root_bus o_root
);
    import cdq_pkg::*;

    logic [SQ_W-1:0] n_cc;
    logic [SQ_W-1:0] r_cc;
    logic [C_W-1:0]  r_ca;
    logic [SQ_W-1:0] r_rad;
    logic [C_W-1:0]  r_cb;

    logic [SQ_W-1:0] st_rem  [SQ_STEPS];
    logic [SQ_W-1:0] st_root [SQ_STEPS];
    logic [C_W-1:0]  st_c    [SQ_STEPS];
    logic [SQ_W-1:0] r_srem  [SQ_STEPS];
    logic [SQ_W-1:0] r_sroot [SQ_STEPS];
    logic [C_W-1:0]  r_sc    [SQ_STEPS];
    logic [SQ_W-1:0] n_srem  [SQ_STEPS];
    logic [SQ_W-1:0] n_sroot [SQ_STEPS];
    logic [SQ_STEPS+1:0] r_v;

    assign n_cc = i_cos.c * i_cos.c;

    always_comb begin
        st_rem[0]  = r_rad;
        st_root[0] = '0;
        st_c[0]    = r_cb;
        for (int s = 1; s < SQ_STEPS; s++) begin
            st_rem[s]  = r_srem[s-1];
            st_root[s] = r_sroot[s-1];
            st_c[s]    = r_sc[s-1];
        end
    end

    // One result bit per stage, trial bit moving down two places each time
    always_comb begin
        logic [SQ_W-1:0] bitv;
        logic [SQ_W-1:0] trial;
        for (int s = 0; s < SQ_STEPS; s++) begin
            bitv  = SQ_W'(1) << (2 * (SQ_STEPS - 1 - s));
            trial = st_root[s] + bitv;
            if (st_rem[s] >= trial) begin
                n_srem[s]  = st_rem[s] - trial;
                n_sroot[s] = (st_root[s] >> 1) + bitv;
            end else begin
                n_srem[s]  = st_rem[s];
                n_sroot[s] = st_root[s] >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[SQ_STEPS:0], i_cos.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cc    <= n_cc;
            r_ca    <= i_cos.c;
            r_rad   <= ONE_Q60 - r_cc;
            r_cb    <= r_ca;
            r_srem  <= n_srem;
            r_sroot <= n_sroot;
            r_sc    <= st_c;
        end
    end

    assign o_root.valid = r_v[SQ_STEPS+1];
    assign o_root.c     = r_sc[SQ_STEPS-1];
    assign o_root.s     = r_sroot[SQ_STEPS-1][C_W-1:0];

endmodule

/* src/cdq_cordic.sv */
// Angle stage: 20-stage CORDIC vectoring of (c, s) to atan2 in Q20,
// then rounding to Q14 (twice the angle in Q13) into the output register. Uses cdq_pkg.
module cdq_cordic (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  cdq_pkg::t_root_bus i_root,
    output cdq_pkg::t_ang_bus  o_ang
);
    import cdq_pkg::*;

    logic signed [X_W-1:0] st_x [CORDIC_STEPS];
    logic signed [X_W-1:0] st_y [CORDIC_STEPS];
    logic signed [Z_W-1:0] st_z [CORDIC_STEPS];
    logic signed [X_W-1:0] r_x  [CORDIC_STEPS];
    logic signed [X_W-1:0] r_y  [CORDIC_STEPS];
    logic signed [Z_W-1:0] r_z  [CORDIC_STEPS];
    logic signed [X_W-1:0] n_x  [CORDIC_STEPS];
    logic signed [X_W-1:0] n_y  [CORDIC_STEPS];
    logic signed [Z_W-1:0] n_z  [CORDIC_STEPS];
    logic [CORDIC_STEPS-1:0] r_v;
    logic                    r_ov;
    logic [OUT_W-1:0]        r_ang;
    logic [OUT_W-1:0]        n_ang;

    always_comb begin
        st_x[0] = $signed({{(X_W-C_W){1'b0}}, i_root.c});
        st_y[0] = $signed({{(X_W-C_W){1'b0}}, i_root.s});
        st_z[0] = '0;
        for (int i = 1; i < CORDIC_STEPS; i++) begin
            st_x[i] = r_x[i-1];
            st_y[i] = r_y[i-1];
            st_z[i] = r_z[i-1];
        end
    end

    // Rotate towards y = 0; arithmetic shifts round towards minus infinity
    always_comb begin
        logic signed [X_W-1:0] xs;
        logic signed [X_W-1:0] ys;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            xs = st_x[i] >>> i;
            ys = st_y[i] >>> i;
            if (st_y[i] > 0) begin
                n_x[i] = st_x[i] + ys;
                n_y[i] = st_y[i] - xs;
                n_z[i] = st_z[i] + ATAN_Q20[i];
            end else begin
                n_x[i] = st_x[i] - ys;
                n_y[i] = st_y[i] + xs;
                n_z[i] = st_z[i] - ATAN_Q20[i];
            end
        end
    end

    always_comb begin
        logic signed [Z_W-1:0] zr;
        logic [Z_W-7:0]        q;
        zr = r_z[CORDIC_STEPS-1] + Z_ROUND;
        q  = zr[Z_W-1:6];
        if (r_z[CORDIC_STEPS-1] <= 0) begin
            n_ang = '0;
        end else if (q > (Z_W-6)'(OUT_MAX)) begin
            n_ang = OUT_MAX;
        end else begin
            n_ang = q[OUT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v  <= '0;
            r_ov <= 1'b0;
        end else if (i_en) begin
            r_v  <= {r_v[CORDIC_STEPS-2:0], i_root.valid};
            r_ov <= r_v[CORDIC_STEPS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x   <= n_x;
            r_y   <= n_y;
            r_z   <= n_z;
            r_ang <= n_ang;
        end
    end

    assign o_ang.valid = r_ov;
    assign o_ang.angle = r_ang;

endmodule

/* src/cdq_checker.sv */
// Port-level checks for the cubic disorientation block, bound to the top level.
// Uses cdq_pkg for the output range.
module cdq_checker (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_in_ready,
    input logic                     i_out_valid,
    input logic                     i_out_ready,
    input logic [cdq_pkg::OUT_W-1:0] i_angle
);
    import cdq_pkg::*;

    // A stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_angle <= OUT_MAX)
        else $error("angle above pi");

    // An empty output register never back-pressures the input
    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input refused with output register empty");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result offered straight after reset");

endmodule

bind cubic_disorientation_quaternion cdq_checker u_cdq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_angle     (o_out.disorientation_angle)
);

/* sim/cdq_angle_scoreboard.sv */
// Scoreboard for the cubic disorientation block: watches both streams,
// predicts each angle from the accepted quaternion pair and compares in order.
// Depends on cdq_pkg and the stream interfaces in cdq_if.sv.
module cdq_angle_scoreboard (
    input  logic i_clk,
    input  logic i_rst_n,
    cdq_in_if    i_pair,
    cdq_out_if   i_angle,
    output int   o_mismatches,
    output int   o_pending
);
    import cdq_pkg::*;

    localparam longint unsigned HALF_Q16 = 64'd32768;

    typedef struct {
        logic [OUT_W-1:0] angle;
        int unsigned      seq;
    } t_angle_rec;

    t_angle_rec  angle_fifo [$];
    t_angle_rec  oldest;
    t_angle_rec  incoming;
    int          mismatch_count = 0;
    int          pending_count  = 0;
    int unsigned pair_seq       = 0;
    t_quat       qa;
    t_quat       qb;

    assign o_mismatches = mismatch_count;
    assign o_pending    = pending_count;

    task automatic report_mismatch(input string what);
        $display("[%0t] angle check: %s", $time, what);
        mismatch_count++;
    endtask

    function automatic longint unsigned mag64(input longint v);
        return (v < 0) ? longint'(-v) : v;
    endfunction

    function automatic longint unsigned larger(input longint unsigned m,
                                               input longint unsigned v);
        return (v > m) ? v : m;
    endfunction

    function automatic longint unsigned floor_sqrt(input longint unsigned n);
        longint unsigned root;
        longint unsigned probe;
        root  = 0;
        probe = 64'd1 << 62;
        while (probe > n) probe >>= 2;
        while (probe != 0) begin
            if (n >= root + probe) begin
                n    = n - (root + probe);
                root = (root >> 1) + probe;
            end else begin
                root = root >> 1;
            end
            probe >>= 2;
        end
        return root;
    endfunction

    // Angle of a * conj(b) reduced by the 24 cubic symmetries, Q2.13 radians
    function automatic logic [OUT_W-1:0] disorientation_q13(input t_quat a, input t_quat b);
        longint          aw, ax, ay, az, bw, bx, by, bz;
        longint          d [4];
        longint          sum;
        longint unsigned m, c, s;
        longint          x, y, z, xs, ys, ang;
        aw = a.w; ax = a.x; ay = a.y; az = a.z;
        bw = b.w; bx = b.x; by = b.y; bz = b.z;

        d[0] =  aw * bw + ax * bx + ay * by + az * bz;
        d[1] = -aw * bx + ax * bw - ay * bz + az * by;
        d[2] = -aw * by + ax * bz + ay * bw - az * bx;
        d[3] = -aw * bz - ax * by + ay * bx + az * bw;

        m = 0;
        for (int i = 0; i < N_COMP; i++) m = larger(m, mag64(d[i]) << 16);
        for (int i = 0; i < N_PAIRIDX; i++) begin
            m = larger(m, mag64(d[PAIR_A[i]] + d[PAIR_B[i]]) * 64'(K_PAIR));
            m = larger(m, mag64(d[PAIR_A[i]] - d[PAIR_B[i]]) * 64'(K_PAIR));
        end
        for (int i = 0; i < N_QUAD; i++) begin
            sum = d[0];
            sum += (i & 4) ? -d[1] : d[1];
            sum += (i & 2) ? -d[2] : d[2];
            sum += (i & 1) ? -d[3] : d[3];
            m = larger(m, mag64(sum) * HALF_Q16);
        end

        if (m > ONE_Q44) m = ONE_Q44;
        c = m >> 14;
        s = floor_sqrt((64'd1 << 60) - c * c);

        // acos(c) = atan2(s, c) by vectoring; >>> on a signed longint floors
        x = c;
        y = s;
        z = 0;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
                x = x + ys;
                y = y - xs;
                z = z + ATAN_Q20[i];
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - ATAN_Q20[i];
            end
        end

        if (z <= 0) begin
            ang = 0;
        end else begin
            ang = (z + 32) >>> 6;
        end
        if (ang > OUT_MAX) ang = OUT_MAX;
        return OUT_W'(ang);
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_angle.valid && i_angle.ready) begin
                if (angle_fifo.size() == 0) begin
                    report_mismatch($sformatf("unexpected result %0d",
                                              i_angle.disorientation_angle));
                end else begin
                    oldest = angle_fifo.pop_front();
                    if (i_angle.disorientation_angle !== oldest.angle) begin
                        report_mismatch($sformatf("pair %0d: got %0d, want %0d", oldest.seq,
                                                  i_angle.disorientation_angle, oldest.angle));
                    end
                end
            end
            if (i_pair.valid && i_pair.ready) begin
                qa = {i_pair.a_w, i_pair.a_x, i_pair.a_y, i_pair.a_z};
                qb = {i_pair.b_w, i_pair.b_x, i_pair.b_y, i_pair.b_z};
                incoming   = '{angle: disorientation_q13(qa, qb), seq: pair_seq};
                angle_fifo = {angle_fifo, incoming};
                pair_seq++;
            end
            pending_count <= angle_fifo.size();
        end
    end

endmodule

/* sim/testbench.sv */
// Top of the cubic disorientation testbench: clock, reset, quaternion stimulus,
// output back-pressure and the verdict. Depends on cdq_pkg, cdq_if.sv, the block
// and cdq_angle_scoreboard.
module testbench;
    import cdq_pkg::*;

    localparam int ITEMS_PER_PHASE = 395;
    localparam int TAIL_CYCLES     = 80;

    logic i_clk;
    logic i_rst_n;
    int   mismatches;
    int   pending;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;

    cdq_in_if  pair_if ();
    cdq_out_if angle_if ();

    cubic_disorientation_quaternion dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (pair_if),
        .o_out   (angle_if)
    );

    cdq_angle_scoreboard u_scoreboard (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pair       (pair_if),
        .i_angle      (angle_if),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Receiver back-pressure, one decision per cycle
    initial begin
        angle_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            angle_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    initial begin
        #4_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic t_quat quat(input int w, input int x, input int y, input int z);
        t_quat q;
        q.w = t_in_word'(w);
        q.x = t_in_word'(x);
        q.y = t_in_word'(y);
        q.z = t_in_word'(z);
        return q;
    endfunction

    function automatic t_quat random_orientation();
        real v [4];
        real norm;
        do begin
            for (int k = 0; k < 4; k++) v[k] = (real'($urandom_range(0, 20000)) - 10000.0) / 1e4;
            norm = $sqrt(v[0] * v[0] + v[1] * v[1] + v[2] * v[2] + v[3] * v[3]);
        end while (norm < 0.1);
        return quat(int'(v[0] / norm * 16384.0), int'(v[1] / norm * 16384.0),
                    int'(v[2] / norm * 16384.0), int'(v[3] / norm * 16384.0));
    endfunction

    function automatic t_quat perturbed(input t_quat q, input int spread);
        return quat(int'(q.w) + int'($urandom_range(0, 2 * spread)) - spread,
                    int'(q.x) + int'($urandom_range(0, 2 * spread)) - spread,
                    int'(q.y) + int'($urandom_range(0, 2 * spread)) - spread,
                    int'(q.z) + int'($urandom_range(0, 2 * spread)) - spread);
    endfunction

    // Permute and re-sign the components: often lands on a symmetry-equivalent pose
    function automatic t_quat shuffled(input t_quat q);
        int comp [4];
        int j, tmp;
        comp = '{int'(q.w), int'(q.x), int'(q.y), int'(q.z)};
        for (int k = 3; k > 0; k--) begin
            j       = $urandom_range(0, k);
            tmp     = comp[k];
            comp[k] = comp[j];
            comp[j] = tmp;
        end
        for (int k = 0; k < 4; k++) if ($urandom_range(0, 1)) comp[k] = -comp[k];
        return quat(comp[0], comp[1], comp[2], comp[3]);
    endfunction

    task automatic send_pair(input t_quat a, input t_quat b);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            pair_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        pair_if.valid <= 1'b1;
        pair_if.a_w   <= a.w;
        pair_if.a_x   <= a.x;
        pair_if.a_y   <= a.y;
        pair_if.a_z   <= a.z;
        pair_if.b_w   <= b.w;
        pair_if.b_x   <= b.x;
        pair_if.b_y   <= b.y;
        pair_if.b_z   <= b.z;
        do @(posedge i_clk); while (!pair_if.ready);
    endtask

    // Drop valid and hold until every predicted angle has come back
    task automatic hold_until_drained();
        pair_if.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic send_random_pair();
        t_quat a;
        t_quat b;
        int    sel;
        sel = $urandom_range(0, 99);
        a   = random_orientation();
        if (sel < 45) begin
            b = random_orientation();
        end else if (sel < 70) begin
            b = perturbed(a, $urandom_range(1, 400));
        end else if (sel < 88) begin
            b = perturbed(shuffled(a), $urandom_range(0, 30));
        end else begin
            a = t_quat'({$urandom, $urandom});
            b = t_quat'({$urandom, $urandom});
        end
        send_pair(a, b);
    endtask

    task automatic send_directed();
        t_quat ident;
        ident = quat(16384, 0, 0, 0);
        send_pair(ident, ident);
        send_pair(ident, quat(0, 0, 0, 0));
        send_pair(quat(0, 0, 0, 0), quat(0, 0, 0, 0));
        send_pair(ident, quat(11585, 0, 0, 11585));
        send_pair(ident, quat(15137, 0, 0, 6270));
        send_pair(ident, quat(15137, 6270, 0, 0));
        send_pair(ident, quat(15625, 0, 0, 4927));
        send_pair(ident, quat(-16384, 0, 0, 0));
        send_pair(ident, quat(0, 16384, 0, 0));
        send_pair(ident, quat(0, 0, 0, -16384));
        send_pair(ident, quat(8192, 8192, 8192, 8192));
        send_pair(ident, quat(14189, 4730, 4730, 4730));
        send_pair(ident, quat(16383, 1, 0, 0));
        send_pair(quat(0, 0, 0, 16384), quat(0, 0, 16384, 0));
        send_pair(quat(1, 0, 0, 0), quat(1, 0, 0, 0));
        // non-unit and out-of-range words
        send_pair(ident, quat(16384, 16384, 16384, 16384));
        send_pair(quat(-16384, -16384, -16384, -16384), quat(16384, 16384, 16384, 16384));
        send_pair(quat(32767, 32767, 32767, 32767), quat(32767, 32767, 32767, 32767));
        send_pair(quat(-32768, -32768, -32768, -32768), quat(-32768, -32768, -32768, -32768));
        send_pair(quat(32767, -32768, 32767, -32768), quat(-32768, 32767, -32768, 32767));
        send_pair(quat(-32768, 0, 0, 0), quat(0, 0, 0, 1));
    endtask

    initial begin
        int idle_pct [4];
        int stall_pct [4];
        idle_pct  = '{0, 71, 0, 29};
        stall_pct = '{0, 0, 71, 29};

        i_rst_n       <= 1'b0;
        pair_if.valid <= 1'b0;
        pair_if.a_w   <= '0;
        pair_if.a_x   <= '0;
        pair_if.a_y   <= '0;
        pair_if.a_z   <= '0;
        pair_if.b_w   <= '0;
        pair_if.b_x   <= '0;
        pair_if.b_y   <= '0;
        pair_if.b_z   <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_directed();
        hold_until_drained();

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = idle_pct[ph];
            recv_stall_pct = stall_pct[ph];
            repeat (ITEMS_PER_PHASE) send_random_pair();
            hold_until_drained();
        end

        // catch any stray result after the last expected one
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
